// File: rtl/tmsl_pkg.sv
// ----------------------------------------------------------------------------
// tmsl_pkg
// Shared constants and types for the tracker motor slew limiter.
// ----------------------------------------------------------------------------
package tmsl_pkg;

  // default angle resolution: 2^-8 degree per count
  localparam int ANGLE_FRAC_DEF = 8;

  localparam int SPD_W     = 17;          // speed registers, counts per second
  localparam int DZ_W      = 12;          // dead zone half width
  localparam int TIME_W    = 17;          // elapsed time, 1/65536 s
  localparam int TIME_FRAC = 16;
  localparam logic [TIME_W-1:0] TIME_ONE = TIME_W'(1 << TIME_FRAC);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SPD_W;

  localparam logic [SPD_W-1:0] AZ_SPEED_RST  = SPD_W'(46080);
  localparam logic [SPD_W-1:0] INC_SPEED_RST = SPD_W'(46080);
  localparam logic [DZ_W-1:0]  DEAD_ZONE_RST = DZ_W'(1280);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AZ_SPEED  = 2'd0,
    CFG_INC_SPEED = 2'd1,
    CFG_DEAD_ZONE = 2'd2
  } cfg_idx_t;

endpackage

// File: rtl/tracker_motor_slew_limiter_unit.sv
// ----------------------------------------------------------------------------
// tracker_motor_slew_limiter_unit
// Two-axis tracker slew limiter with azimuth dead zones.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  in      | sink      | in_valid / in_stall   | target_azimuth, target_inclination,
//          |           |                       | elapsed
//  out     | source    | out_valid / out_stall | motor_azimuth, motor_inclination,
//          |           |                       | moved
//  cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One item per cycle sustained while out_stall is low; each item is registered
//  in stage 1 on accept, then in the output register, where out_valid rises.
//  The target is folded/clamped and both step limits formed (one 17x17 multiply
//  per axis) ahead of stage 1; stage 2 steps the held position into the result.
//  Reset clears held position to zero and loads default speeds and dead zone.
//  out_stall holds the result; in_stall rises only while both stages are full
//  and out_stall is high. cfg_ready is always high.
// ----------------------------------------------------------------------------
module tracker_motor_slew_limiter_unit #(
  parameter int ANGLE_FRACTION_BITS = tmsl_pkg::ANGLE_FRAC_DEF,
  localparam int AZ_IN_W = $clog2(360 * (2 ** ANGLE_FRACTION_BITS) + 1),
  localparam int MOT_W   = $clog2(180 * (2 ** ANGLE_FRACTION_BITS) + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic        [AZ_IN_W-1:0]         in_target_azimuth,
  input  logic signed [AZ_IN_W-1:0]         in_target_inclination,
  input  logic        [tmsl_pkg::TIME_W-1:0] in_elapsed,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic        [MOT_W-1:0]           out_motor_azimuth,
  output logic signed [MOT_W-1:0]           out_motor_inclination,
  output logic                              out_moved,

  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tmsl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tmsl_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import tmsl_pkg::*;

  localparam int D90  = 90  * (2 ** ANGLE_FRACTION_BITS);
  localparam int D180 = 180 * (2 ** ANGLE_FRACTION_BITS);
  localparam int D360 = 360 * (2 ** ANGLE_FRACTION_BITS);
  localparam int ZU_W = ((AZ_IN_W > DZ_W) ? AZ_IN_W : DZ_W) + 1;
  localparam int INC_X_W = AZ_IN_W + 1;
  localparam int VAL_W = MOT_W + 1;
  localparam int PROD_W = SPD_W + TIME_W;

  localparam logic [AZ_IN_W-1:0] D180_A = AZ_IN_W'(D180);
  localparam logic [AZ_IN_W-1:0] D360_A = AZ_IN_W'(D360);
  localparam logic [ZU_W-1:0]    D180_Z = ZU_W'(D180);
  localparam logic [ZU_W-1:0]    D360_Z = ZU_W'(D360);
  localparam logic signed [INC_X_W-1:0] P90_X = INC_X_W'(D90);
  localparam logic signed [INC_X_W-1:0] N90_X = -INC_X_W'(D90);

  // open intervals around 0, 180 and 360 degrees
  function automatic logic in_zone(input logic [ZU_W-1:0] a, input logic [DZ_W-1:0] h);
    logic [ZU_W-1:0] hz;
    logic [ZU_W-1:0] ah;
    hz = ZU_W'(h);
    ah = a + hz;
    in_zone = (a < hz) ||
              (ah > D180_Z && a < D180_Z + hz) ||
              (ah > D360_Z && a < D360_Z + hz);
  endfunction

  // configuration
  logic [SPD_W-1:0] az_speed_r;
  logic [SPD_W-1:0] inc_speed_r;
  logic [DZ_W-1:0]  dz_r;

  // stage 1
  logic                     s1_valid_r;
  logic [MOT_W-1:0]         s1_az_r;
  logic signed [MOT_W-1:0]  s1_inc_r;
  logic [SPD_W-1:0]         s1_az_lim_r;
  logic [SPD_W-1:0]         s1_inc_lim_r;
  logic                     s1_tzone_r;

  // held motor position
  logic [MOT_W-1:0]         held_az_r;
  logic signed [MOT_W-1:0]  held_inc_r;
  logic [MOT_W-1:0]         held_az_nxt;
  logic signed [MOT_W-1:0]  held_inc_nxt;

  logic                     out_valid_r;
  logic [MOT_W-1:0]         out_az_r;
  logic signed [MOT_W-1:0]  out_inc_r;
  logic                     out_moved_r;

  logic                     in_acc;
  logic                     adv;

  // stage 1 datapath
  logic [AZ_IN_W-1:0]       az_sat;
  logic                     fold;
  logic [AZ_IN_W-1:0]       az_fold;
  logic signed [INC_X_W-1:0] inc_ext;
  logic signed [INC_X_W-1:0] inc_neg;
  logic signed [INC_X_W-1:0] inc_clamp;
  logic [TIME_W-1:0]        t_sat;
  logic [PROD_W-1:0]        az_prod;
  logic [PROD_W-1:0]        inc_prod;
  logic                     tzone;

  // stage 2 datapath
  logic                     hold;
  logic signed [VAL_W-1:0]  az_step;
  logic signed [VAL_W-1:0]  inc_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      az_speed_r  <= AZ_SPEED_RST;
      inc_speed_r <= INC_SPEED_RST;
      dz_r        <= DEAD_ZONE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_AZ_SPEED:  az_speed_r  <= cfg_data[SPD_W-1:0];
        CFG_INC_SPEED: inc_speed_r <= cfg_data[SPD_W-1:0];
        CFG_DEAD_ZONE: dz_r        <= cfg_data[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    az_sat    = (in_target_azimuth > D360_A) ? D360_A : in_target_azimuth;
    fold      = az_sat > D180_A;
    az_fold   = fold ? (az_sat - D180_A) : az_sat;
    inc_ext   = INC_X_W'(in_target_inclination);
    inc_neg   = fold ? -inc_ext : inc_ext;
    if (inc_neg < N90_X) begin
      inc_clamp = N90_X;
    end else if (inc_neg > P90_X) begin
      inc_clamp = P90_X;
    end else begin
      inc_clamp = inc_neg;
    end
    t_sat    = (in_elapsed > TIME_ONE) ? TIME_ONE : in_elapsed;
    az_prod  = PROD_W'(az_speed_r) * PROD_W'(t_sat);
    inc_prod = PROD_W'(inc_speed_r) * PROD_W'(t_sat);
    tzone    = in_zone(ZU_W'(az_fold), dz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_az_r      <= az_fold[MOT_W-1:0];
      s1_inc_r     <= inc_clamp[MOT_W-1:0];
      s1_az_lim_r  <= az_prod[TIME_FRAC +: SPD_W];
      s1_inc_lim_r <= inc_prod[TIME_FRAC +: SPD_W];
      s1_tzone_r   <= tzone;
    end
  end

  tmsl_axis_step #(.VAL_W(VAL_W), .LIM_W(SPD_W)) u_az_step (
    .cur_pos  ({1'b0, held_az_r}),
    .tgt_pos  ({1'b0, s1_az_r}),
    .limit    (s1_az_lim_r),
    .next_pos (az_step)
  );

  tmsl_axis_step #(.VAL_W(VAL_W), .LIM_W(SPD_W)) u_inc_step (
    .cur_pos  (VAL_W'(held_inc_r)),
    .tgt_pos  (VAL_W'(s1_inc_r)),
    .limit    (s1_inc_lim_r),
    .next_pos (inc_step)
  );

  always_comb begin
    // still only when both target and held azimuth sit in a dead zone
    hold         = s1_tzone_r && in_zone(ZU_W'(held_az_r), dz_r);
    held_az_nxt  = hold ? held_az_r  : az_step[MOT_W-1:0];
    held_inc_nxt = hold ? held_inc_r : inc_step[MOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_az_r   <= '0;
      held_inc_r  <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      held_az_r   <= held_az_nxt;
      held_inc_r  <= held_inc_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_az_r    <= held_az_nxt;
      out_inc_r   <= held_inc_nxt;
      out_moved_r <= !hold;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_motor_azimuth     = out_az_r;
  assign out_motor_inclination = out_inc_r;
  assign out_moved             = out_moved_r;

endmodule

// File: rtl/tmsl_axis_step.sv
// ----------------------------------------------------------------------------
// tmsl_axis_step
// Moves one axis toward its target by at most the step limit, no overshoot.
// ----------------------------------------------------------------------------
module tmsl_axis_step #(
  parameter int VAL_W = 17,
  parameter int LIM_W = 17
) (
  input  logic signed [VAL_W-1:0] cur_pos,
  input  logic signed [VAL_W-1:0] tgt_pos,
  input  logic        [LIM_W-1:0] limit,
  output logic signed [VAL_W-1:0] next_pos
);

  localparam int OFF_W = VAL_W + 1;
  localparam int MAG_W = (OFF_W > LIM_W) ? OFF_W : LIM_W;

  logic [OFF_W-1:0] cur_ext;
  logic [OFF_W-1:0] tgt_ext;
  logic [OFF_W-1:0] off;
  logic [OFF_W-1:0] mag;
  logic [MAG_W-1:0] mag_w;
  logic [MAG_W-1:0] lim_w;
  logic [MAG_W-1:0] step_w;
  logic [OFF_W-1:0] step;
  logic [OFF_W-1:0] sum;
  logic             neg;

  always_comb begin
    cur_ext  = {cur_pos[VAL_W-1], cur_pos};
    tgt_ext  = {tgt_pos[VAL_W-1], tgt_pos};
    off      = tgt_ext - cur_ext;
    neg      = off[OFF_W-1];
    mag      = neg ? (~off + OFF_W'(1)) : off;
    mag_w    = MAG_W'(mag);
    lim_w    = MAG_W'(limit);
    step_w   = (mag_w > lim_w) ? lim_w : mag_w;
    // step never exceeds mag, so the narrow form holds it
    step     = step_w[OFF_W-1:0];
    sum      = neg ? (cur_ext - step) : (cur_ext + step);
    next_pos = sum[VAL_W-1:0];
  end

endmodule

// File: rtl/tmsl_checker.sv
// ----------------------------------------------------------------------------
// tmsl_checker
// Port-level checks for the tracker motor slew limiter.
// ----------------------------------------------------------------------------
module tmsl_checker #(
  parameter int ANGLE_FRACTION_BITS = tmsl_pkg::ANGLE_FRAC_DEF,
  localparam int MOT_W = $clog2(180 * (2 ** ANGLE_FRACTION_BITS) + 1)
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic        [MOT_W-1:0]  out_motor_azimuth,
  input logic signed [MOT_W-1:0]  out_motor_inclination,
  input logic                     out_moved
);

  localparam logic        [MOT_W-1:0] AZ_MAX  = MOT_W'(180 * (2 ** ANGLE_FRACTION_BITS));
  localparam logic signed [MOT_W-1:0] INC_MAX = MOT_W'(90 * (2 ** ANGLE_FRACTION_BITS));
  localparam logic signed [MOT_W-1:0] INC_MIN = -MOT_W'(90 * (2 ** ANGLE_FRACTION_BITS));

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_motor_azimuth) &&
      $stable(out_motor_inclination) && $stable(out_moved))
    else $error("stalled result changed");

  // the input side only backs up while a result sits stalled
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_az_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_motor_azimuth <= AZ_MAX)
    else $error("motor azimuth beyond 180 degrees");

  a_inc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_motor_inclination <= INC_MAX && out_motor_inclination >= INC_MIN)
    else $error("motor inclination beyond 90 degrees");

endmodule

bind tracker_motor_slew_limiter_unit tmsl_checker #(
  .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
) u_tmsl_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_stall              (in_stall),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_motor_azimuth     (out_motor_azimuth),
  .out_motor_inclination (out_motor_inclination),
  .out_moved             (out_moved)
);

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tracker motor slew limiter. A predictor tracks
// the held azimuth and inclination, the speed limits and the dead zones, and
// every result is checked field by field in item order. Directed items cover
// folding, clamping, saturation and the dead-zone hold; random phases then
// sweep register settings, input idling, output stalls and back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tmsl_pkg::*;

  localparam int AZ_W  = 17;
  localparam int MOT_W = 16;

  // 180, 360 and 90 degrees in 1/256 degree
  localparam int DEG180 = 46080;
  localparam int DEG360 = 92160;
  localparam int DEG90  = 23040;
  localparam int T_ONE  = 65536;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct {
    logic [MOT_W-1:0] az;
    logic [MOT_W-1:0] inc;
    logic             moved;
  } motor_pos_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic        [AZ_W-1:0]   in_target_azimuth = '0;
  logic signed [AZ_W-1:0]   in_target_inclination = '0;
  logic        [TIME_W-1:0] in_elapsed = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic        [MOT_W-1:0]  out_motor_azimuth;
  logic signed [MOT_W-1:0]  out_motor_inclination;
  logic                     out_moved;

  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  tracker_motor_slew_limiter_unit dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [SPD_W-1:0] az_rate   = AZ_SPEED_RST;
  logic [SPD_W-1:0] inc_rate  = INC_SPEED_RST;
  logic [DZ_W-1:0]  zone_half = DEAD_ZONE_RST;
  int               held_az   = 0;
  int               held_inc  = 0;

  motor_pos_t motor_pos_q[$];
  int         err_count = 0;

  // idling controls
  int gap_max    = 0;
  int burst_max  = 1;
  int burst_left = 0;
  int stall_max  = 0;
  int free_max   = 1;
  int recv_hold  = 0;
  int run_left   = 0;
  logic stall_phase = 1'b0;

  function automatic bit in_dead_zone(input int az);
    int h;
    h = int'(zone_half);
    return (-h < az && az < h) ||
           (DEG180 - h < az && az < DEG180 + h) ||
           (DEG360 - h < az && az < DEG360 + h);
  endfunction

  function automatic int slew_axis(input int cur, input int target,
                                   input logic [SPD_W-1:0] rate, input int t);
    longint lim;
    int     off;
    int     mag;
    lim = (longint'(rate) * longint'(t)) >>> 16;
    off = target - cur;
    mag = (off < 0) ? -off : off;
    if (mag > lim) mag = int'(lim);
    return (off < 0) ? cur - mag : cur + mag;
  endfunction

  // applies the item currently on the input port to the predictor state
  task automatic predict_motor_step();
    motor_pos_t res;
    int az;
    int inc;
    int t;
    az  = int'(in_target_azimuth);
    inc = int'(in_target_inclination);
    t   = int'(in_elapsed);
    if (t > T_ONE) t = T_ONE;
    if (az > DEG360) az = DEG360;
    if (az > DEG180) begin
      az  = az - DEG180;
      inc = -inc;
    end
    if (inc < -DEG90) inc = -DEG90;
    if (inc > DEG90) inc = DEG90;
    res.moved = 1'b0;
    if (!(in_dead_zone(az) && in_dead_zone(held_az))) begin
      held_az  = slew_axis(held_az, az, az_rate, t);
      held_inc = slew_axis(held_inc, inc, inc_rate, t);
      res.moved = 1'b1;
    end
    res.az  = held_az[MOT_W-1:0];
    res.inc = held_inc[MOT_W-1:0];
    motor_pos_q.push_back(res);
  endtask

  // sender: bursts of items separated by random gaps
  task automatic send_target(input int az, input int inc, input int t);
    int gap;
    if (gap_max > 0 && burst_left == 0) begin
      gap = $urandom_range(1, gap_max);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
      burst_left = $urandom_range(1, burst_max);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid              = 1'b1;
    in_target_azimuth     = az[AZ_W-1:0];
    in_target_inclination = inc[AZ_W-1:0];
    in_elapsed            = t[TIME_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_motor_step();
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (motor_pos_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_AZ_SPEED:  az_rate   = cfg_data;
      CFG_INC_SPEED: inc_rate  = cfg_data;
      CFG_DEAD_ZONE: zone_half = cfg_data[DZ_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_idling(input int gmax, input int bmax, input int smax, input int fmax);
    gap_max    = gmax;
    burst_max  = bmax;
    burst_left = 0;
    stall_max  = smax;
    free_max   = fmax;
  endtask

  // azimuth just around a dead-zone edge
  function automatic int zone_edge_az();
    int base;
    int d;
    base = DEG180 * int'($urandom_range(0, 2));
    d = int'(zone_half) + int'($urandom_range(0, 4)) - 2;
    base = $urandom_range(0, 1) ? base + d : base - d;
    if (base < 0) base = 0;
    return base;
  endfunction

  task automatic send_random_target();
    int az;
    int inc;
    int t;
    case ($urandom_range(0, 9))
      0, 1:    az = zone_edge_az();
      2:       az = $urandom_range(0, 131071);
      3:       az = $urandom_range(0, 600);
      default: az = $urandom_range(0, DEG360);
    endcase
    if ($urandom_range(0, 4) == 0) inc = int'($urandom_range(0, 131071)) - 65536;
    else inc = int'($urandom_range(0, 2 * DEG360)) - DEG360 / 2 * 1;
    case ($urandom_range(0, 9))
      0:          t = T_ONE;
      1:          t = $urandom_range(0, 131071);
      2, 3, 4:    t = $urandom_range(0, T_ONE);
      default:    t = $urandom_range(0, 4096);
    endcase
    send_target(az, inc, t);
  endtask

  // receiver stall pattern plus optional long hold-off
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      out_stall <= 1'b1;
      recv_hold--;
    end else if (stall_max == 0) begin
      out_stall <= 1'b0;
    end else begin
      if (run_left == 0) begin
        stall_phase = ~stall_phase;
        run_left = stall_phase ? $urandom_range(1, stall_max) : $urandom_range(1, free_max);
      end
      run_left--;
      out_stall <= stall_phase;
    end
  end

  always @(posedge clk) begin : check_results
    motor_pos_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (motor_pos_q.size() == 0) begin
        $error("result with no item pending: az %0d inc %0d moved %0d",
               out_motor_azimuth, out_motor_inclination, out_moved);
        err_count++;
      end else begin
        want = motor_pos_q.pop_front();
        if (out_motor_azimuth !== want.az) begin
          $error("motor_azimuth expected %0d actual %0d", want.az, out_motor_azimuth);
          err_count++;
        end
        if (out_motor_inclination !== want.inc) begin
          $error("motor_inclination expected %0d actual %0d",
                 $signed(want.inc), out_motor_inclination);
          err_count++;
        end
        if (out_moved !== want.moved) begin
          $error("moved expected %0d actual %0d", want.moved, out_moved);
          err_count++;
        end
      end
    end
  end

  // folding, clamping, saturation and the dead-zone hold, from reset defaults
  task automatic test_directed_edges();
    set_idling(0, 1, 0, 1);
    send_target(0, 0, 0);                 // target and held both in zone
    send_target(100, 1000, T_ONE);
    send_target(DEG180, 0, T_ONE);
    send_target(DEG360, -46080, T_ONE);   // folds onto 180 degrees
    send_target(131071, 65535, T_ONE);    // saturates to 360 degrees
    send_target(20000, 46080, 0);         // moves with zero step
    send_target(20000, 46080, T_ONE);
    send_target(DEG180 + 1, 46080, 65537);
    send_target(DEG360 - 1, -65536, 131071);
    send_target(30000, -DEG90 - 1, 1);
    send_target(30000, DEG90 + 1, 32768);
    send_target(1280, 0, T_ONE);          // zone edge is open
    send_target(1279, 0, T_ONE);
    send_target(DEG180 - 1280, 0, T_ONE);
    send_target(DEG180 - 1279, 0, T_ONE);
    send_target(DEG180 + 1279, 0, T_ONE);
    send_target(DEG360 - 1279, 0, T_ONE);
    send_target(65535, -1, 65535);
    send_target(0, 0, 131071);
    wait_results_drained();
  endtask

  task automatic test_register_sweep();
    int setting;
    int az_s;
    int inc_s;
    int dz_s;
    set_idling(3, 8, 2, 4);
    for (setting = 0; setting < 7; setting++) begin
      case (setting)
        0: begin az_s = 0;      inc_s = 0;      dz_s = 0;       end
        1: begin az_s = DEG360; inc_s = DEG360; dz_s = 2560;    end
        2: begin az_s = 131071; inc_s = 131071; dz_s = 4095;    end
        3: begin az_s = 1;      inc_s = 1;      dz_s = 1;       end
        4: begin az_s = 46080;  inc_s = 46080;  dz_s = 'h1F500; end  // upper bits dropped
        5: begin az_s = 300;    inc_s = 92160;  dz_s = 2560;    end
        default: begin
          az_s  = $urandom_range(0, 131071);
          inc_s = $urandom_range(0, 131071);
          dz_s  = $urandom_range(0, 131071);
        end
      endcase
      write_reg(CFG_AZ_SPEED, az_s);
      write_reg(CFG_INC_SPEED, inc_s);
      write_reg(CFG_DEAD_ZONE, dz_s);
      write_reg(CFG_SPARE_IDX, $urandom_range(0, 131071));
      repeat (45) send_random_target();
      wait_results_drained();
    end
    write_reg(CFG_AZ_SPEED, AZ_SPEED_RST);
    write_reg(CFG_INC_SPEED, INC_SPEED_RST);
    write_reg(CFG_DEAD_ZONE, DEAD_ZONE_RST);
  endtask

  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_idling(0, 1, 0, 1);       // no idling on either side
        1: set_idling(4, 12, 3, 5);
        2: set_idling(1, 3, 1, 1);
        3: set_idling(10, 30, 8, 2);
        default: set_idling(2, 6, 0, 1);
      endcase
      if (phase == 4) write_reg(CFG_DEAD_ZONE, 2560);
      repeat (216) send_random_target();
      wait_results_drained();
    end
    write_reg(CFG_DEAD_ZONE, DEAD_ZONE_RST);
  endtask

  // receiver holds off while items keep coming, so the pipe fills and stalls
  task automatic test_output_backpressure();
    set_idling(0, 1, 0, 1);
    recv_hold = 80;
    repeat (40) send_random_target();
    wait_results_drained();
    set_idling(0, 1, 2, 2);
    recv_hold = 30;
    repeat (20) send_random_target();
    wait_results_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_edges();
    test_register_sweep();
    test_random_traffic();
    test_output_backpressure();
    wait_results_drained();
    repeat (10) @(posedge clk);
    if (motor_pos_q.size() != 0) begin
      $error("%0d results never arrived", motor_pos_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: sim.f
rtl/tmsl_pkg.sv
rtl/tmsl_axis_step.sv
rtl/tracker_motor_slew_limiter_unit.sv
rtl/tmsl_checker.sv
dv/tb_top.sv
